// ----- hdl/kmp_pkg.sv -----
// Shared types, codes and the kana lookup table for the kana-to-mora phrase parser.
// Used by every module of the block; depends on nothing.
package kmp_pkg;

   localparam int CODE_W  = 16;
   localparam int CONS_W  = 5;
   localparam int VOWEL_W = 4;
   localparam int IDX_W   = 8;
   localparam int ACC_W   = 9;
   localparam int TOT_W   = 9;
   localparam int PAUSE_W = 10;
   localparam int TDATA_W = 64;

   // input op codes
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // result kinds
   localparam logic KIND_MORA   = 1'b0;
   localparam logic KIND_PHRASE = 1'b1;

   // consonant codes
   localparam logic [CONS_W-1:0] CN_L    = 5'd0;
   localparam logic [CONS_W-1:0] CN_NONE = 5'd1;
   localparam logic [CONS_W-1:0] CN_K    = 5'd2;
   localparam logic [CONS_W-1:0] CN_G    = 5'd3;
   localparam logic [CONS_W-1:0] CN_S    = 5'd4;
   localparam logic [CONS_W-1:0] CN_DZ   = 5'd5;
   localparam logic [CONS_W-1:0] CN_SJ   = 5'd6;
   localparam logic [CONS_W-1:0] CN_DZJ  = 5'd7;
   localparam logic [CONS_W-1:0] CN_T    = 5'd8;
   localparam logic [CONS_W-1:0] CN_D    = 5'd9;
   localparam logic [CONS_W-1:0] CN_TSJ  = 5'd10;
   localparam logic [CONS_W-1:0] CN_Q    = 5'd11;
   localparam logic [CONS_W-1:0] CN_TS   = 5'd12;
   localparam logic [CONS_W-1:0] CN_N    = 5'd13;
   localparam logic [CONS_W-1:0] CN_H    = 5'd14;
   localparam logic [CONS_W-1:0] CN_B    = 5'd15;
   localparam logic [CONS_W-1:0] CN_P    = 5'd16;
   localparam logic [CONS_W-1:0] CN_CH   = 5'd17;
   localparam logic [CONS_W-1:0] CN_PH   = 5'd18;
   localparam logic [CONS_W-1:0] CN_M    = 5'd19;
   localparam logic [CONS_W-1:0] CN_J    = 5'd20;
   localparam logic [CONS_W-1:0] CN_R    = 5'd21;
   localparam logic [CONS_W-1:0] CN_W    = 5'd22;
   localparam logic [CONS_W-1:0] CN_NN   = 5'd23;
   localparam logic [CONS_W-1:0] CN_ZJ   = 5'd24;

   // vowel codes
   localparam logic [VOWEL_W-1:0] VW_A  = 4'd0;
   localparam logic [VOWEL_W-1:0] VW_I  = 4'd1;
   localparam logic [VOWEL_W-1:0] VW_U  = 4'd2;
   localparam logic [VOWEL_W-1:0] VW_E  = 4'd3;
   localparam logic [VOWEL_W-1:0] VW_O  = 4'd4;
   localparam logic [VOWEL_W-1:0] VW_X  = 4'd5;
   localparam logic [VOWEL_W-1:0] VW_JA = 4'd6;
   localparam logic [VOWEL_W-1:0] VW_JU = 4'd7;
   localparam logic [VOWEL_W-1:0] VW_JO = 4'd8;

   // character codes
   localparam logic [CODE_W-1:0] CH_KANA_FIRST = 16'h30A1;
   localparam logic [CODE_W-1:0] CH_KANA_LAST  = 16'h30F3;
   localparam logic [CODE_W-1:0] CH_LONG_MARK  = 16'h30FC;
   localparam logic [CODE_W-1:0] CH_ACCENT     = 16'h0027;
   localparam logic [CODE_W-1:0] CH_SPACE      = 16'h0020;
   localparam logic [CODE_W-1:0] CH_IDEO_SPACE = 16'h3000;
   localparam logic [CODE_W-1:0] CH_IDEO_COMMA = 16'h3001;
   localparam logic [CODE_W-1:0] CH_IDEO_STOP  = 16'h3002;
   localparam logic [CODE_W-1:0] CH_COMMA      = 16'h002C;
   localparam logic [CODE_W-1:0] CH_PERIOD     = 16'h002E;
   localparam logic [CODE_W-1:0] CH_QUESTION   = 16'h003F;
   localparam logic [CODE_W-1:0] CH_FW_QUEST   = 16'hFF1F;
   localparam logic [CODE_W-1:0] CH_SLASH      = 16'h002F;

   localparam logic [PAUSE_W-1:0] PAUSE_NONE  = 10'd0;
   localparam logic [PAUSE_W-1:0] PAUSE_SPACE = 10'd100;
   localparam logic [PAUSE_W-1:0] PAUSE_COMMA = 10'd300;
   localparam logic [PAUSE_W-1:0] PAUSE_STOP  = 10'd1000;

   localparam logic [ACC_W-1:0] ACC_NONE = 9'h1FF;

   typedef struct packed {
      logic [CONS_W-1:0]  cons;
      logic [VOWEL_W-1:0] vowel;
   } kana_type;

   typedef struct packed {
      logic               kind;
      logic [CONS_W-1:0]  consonant;
      logic [VOWEL_W-1:0] vowel;
      logic [IDX_W-1:0]   mora_index;
      logic [ACC_W-1:0]   accent_pos;
      logic [TOT_W-1:0]   mora_total;
      logic [CODE_W-1:0]  delimiter;
      logic [PAUSE_W-1:0] pause_ms;
      logic               last;
   } rsp_type;

   // up to two results of one transaction, handed to the output queue
   typedef struct packed {
      logic       load;
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_load_type;

   function automatic kana_type kana_lookup(input logic [6:0] idx);
      kana_type k;
      unique case (idx)
         7'd0:  k = '{CN_L, VW_A};    7'd1:  k = '{CN_NONE, VW_A};
         7'd2:  k = '{CN_L, VW_I};    7'd3:  k = '{CN_NONE, VW_I};
         7'd4:  k = '{CN_L, VW_U};    7'd5:  k = '{CN_NONE, VW_U};
         7'd6:  k = '{CN_L, VW_E};    7'd7:  k = '{CN_NONE, VW_E};
         7'd8:  k = '{CN_L, VW_O};    7'd9:  k = '{CN_NONE, VW_O};
         7'd10: k = '{CN_K, VW_A};    7'd11: k = '{CN_G, VW_A};
         7'd12: k = '{CN_K, VW_I};    7'd13: k = '{CN_G, VW_I};
         7'd14: k = '{CN_K, VW_U};    7'd15: k = '{CN_G, VW_U};
         7'd16: k = '{CN_K, VW_E};    7'd17: k = '{CN_G, VW_E};
         7'd18: k = '{CN_K, VW_O};    7'd19: k = '{CN_G, VW_O};
         7'd20: k = '{CN_S, VW_A};    7'd21: k = '{CN_DZ, VW_A};
         7'd22: k = '{CN_SJ, VW_I};   7'd23: k = '{CN_DZJ, VW_I};
         7'd24: k = '{CN_S, VW_U};    7'd25: k = '{CN_DZ, VW_U};
         7'd26: k = '{CN_S, VW_E};    7'd27: k = '{CN_DZ, VW_E};
         7'd28: k = '{CN_S, VW_O};    7'd29: k = '{CN_DZ, VW_O};
         7'd30: k = '{CN_T, VW_A};    7'd31: k = '{CN_D, VW_A};
         7'd32: k = '{CN_TSJ, VW_I};  7'd33: k = '{CN_DZJ, VW_I};
         7'd34: k = '{CN_Q, VW_X};    7'd35: k = '{CN_TS, VW_U};
         7'd36: k = '{CN_DZ, VW_U};   7'd37: k = '{CN_T, VW_E};
         7'd38: k = '{CN_D, VW_E};    7'd39: k = '{CN_T, VW_O};
         7'd40: k = '{CN_D, VW_O};
         7'd41: k = '{CN_N, VW_A};    7'd42: k = '{CN_N, VW_I};
         7'd43: k = '{CN_N, VW_U};    7'd44: k = '{CN_N, VW_E};
         7'd45: k = '{CN_N, VW_O};
         7'd46: k = '{CN_H, VW_A};    7'd47: k = '{CN_B, VW_A};
         7'd48: k = '{CN_P, VW_A};    7'd49: k = '{CN_CH, VW_I};
         7'd50: k = '{CN_B, VW_I};    7'd51: k = '{CN_P, VW_I};
         7'd52: k = '{CN_PH, VW_U};   7'd53: k = '{CN_B, VW_U};
         7'd54: k = '{CN_P, VW_U};    7'd55: k = '{CN_H, VW_E};
         7'd56: k = '{CN_B, VW_E};    7'd57: k = '{CN_P, VW_E};
         7'd58: k = '{CN_H, VW_O};    7'd59: k = '{CN_B, VW_O};
         7'd60: k = '{CN_P, VW_O};
         7'd61: k = '{CN_M, VW_A};    7'd62: k = '{CN_M, VW_I};
         7'd63: k = '{CN_M, VW_U};    7'd64: k = '{CN_M, VW_E};
         7'd65: k = '{CN_M, VW_O};
         7'd66: k = '{CN_L, VW_JA};   7'd67: k = '{CN_J, VW_A};
         7'd68: k = '{CN_L, VW_JU};   7'd69: k = '{CN_J, VW_U};
         7'd70: k = '{CN_L, VW_JO};   7'd71: k = '{CN_J, VW_O};
         7'd72: k = '{CN_R, VW_A};    7'd73: k = '{CN_R, VW_I};
         7'd74: k = '{CN_R, VW_U};    7'd75: k = '{CN_R, VW_E};
         7'd76: k = '{CN_R, VW_O};
         7'd77: k = '{CN_W, VW_A};    7'd78: k = '{CN_W, VW_A};
         7'd79: k = '{CN_NONE, VW_I}; 7'd80: k = '{CN_NONE, VW_E};
         7'd81: k = '{CN_NONE, VW_O}; 7'd82: k = '{CN_NN, VW_X};
         default: k = '{CN_NONE, VW_A};
      endcase
      return k;
   endfunction

endpackage

// ----- hdl/kmp_parse_stage.sv -----
// Input register, phrase state and single-pass parse logic of the kana-to-mora parser.
// Produces up to two results per transaction for kmp_rsp_queue; depends on kmp_pkg.
module kmp_parse_stage #(
   parameter int MAX_MORAS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_op,
   input  logic [kmp_pkg::CODE_W-1:0]   req_code,
   input  logic                         load_ok,
   output kmp_pkg::rsp_load_type        rsp_load
);

   localparam int CW = $clog2(MAX_MORAS + 1);
   localparam int XW = (CW > 9) ? CW : 9;

   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic [kmp_pkg::CODE_W-1:0]    in_code_ff;
   logic                          fire;

   logic                          pend_valid_ff, pend_valid_in;
   logic [kmp_pkg::CONS_W-1:0]    pend_cons_ff, pend_cons_in;
   logic [kmp_pkg::VOWEL_W-1:0]   pend_vowel_ff, pend_vowel_in;
   logic [kmp_pkg::CONS_W-1:0]    prev_cons_ff, prev_cons_in;
   logic [kmp_pkg::VOWEL_W-1:0]   prev_vowel_ff, prev_vowel_in;
   logic [CW-1:0]                 mora_count_ff, mora_count_in;
   logic [kmp_pkg::ACC_W-1:0]     accent_at_ff, accent_at_in;
   logic                          word_open_ff, word_open_in;

   logic                          is_kana, is_delim, merged;
   kmp_pkg::kana_type             kana, kana_conv;
   logic [kmp_pkg::VOWEL_W-1:0]   merge_v;
   logic [kmp_pkg::PAUSE_W-1:0]   pause;
   logic [XW-1:0]                 cnt_x;
   kmp_pkg::rsp_load_type         bundle;

   function automatic logic [kmp_pkg::VOWEL_W-1:0] merge_vowel(
      input logic [kmp_pkg::CONS_W-1:0]  c,
      input logic [kmp_pkg::VOWEL_W-1:0] v1,
      input logic [kmp_pkg::VOWEL_W-1:0] v2
   );
      logic small_y, palatal, aieo;
      logic [kmp_pkg::VOWEL_W-1:0] r;
      small_y = (v2 == kmp_pkg::VW_JA) || (v2 == kmp_pkg::VW_JU) || (v2 == kmp_pkg::VW_JO);
      palatal = (c == kmp_pkg::CN_SJ) || (c == kmp_pkg::CN_ZJ) ||
                (c == kmp_pkg::CN_TSJ) || (c == kmp_pkg::CN_DZJ);
      aieo = (v2 == kmp_pkg::VW_A) || (v2 == kmp_pkg::VW_I) ||
             (v2 == kmp_pkg::VW_E) || (v2 == kmp_pkg::VW_O);
      r = v1;
      priority if (v1 == kmp_pkg::VW_I && small_y) begin
         if (palatal || c == kmp_pkg::CN_CH) begin
            r = (v2 == kmp_pkg::VW_JA) ? kmp_pkg::VW_A :
                (v2 == kmp_pkg::VW_JU) ? kmp_pkg::VW_U : kmp_pkg::VW_O;
         end else if (c != kmp_pkg::CN_NONE && c != kmp_pkg::CN_Q && c != kmp_pkg::CN_NN) begin
            r = v2;
         end
      end else if (palatal && v1 == kmp_pkg::VW_I && v2 == kmp_pkg::VW_E) begin
         r = v2;
      end else if ((c == kmp_pkg::CN_T || c == kmp_pkg::CN_D) &&
                   v1 == kmp_pkg::VW_E && v2 == kmp_pkg::VW_I) begin
         r = v2;
      end else if ((c == kmp_pkg::CN_T || c == kmp_pkg::CN_D) &&
                   v1 == kmp_pkg::VW_O && v2 == kmp_pkg::VW_U) begin
         r = v2;
      end else if ((c == kmp_pkg::CN_TSJ || c == kmp_pkg::CN_PH) &&
                   v1 == kmp_pkg::VW_U && aieo) begin
         r = v2;
      end else if (c == kmp_pkg::CN_W && v1 == kmp_pkg::VW_U &&
                   (v2 == kmp_pkg::VW_I || v2 == kmp_pkg::VW_E || v2 == kmp_pkg::VW_O)) begin
         r = v2;
      end else begin
         r = v1;
      end
      return r;
   endfunction

   function automatic kmp_pkg::rsp_type mora_rec(
      input logic [kmp_pkg::CONS_W-1:0]  c,
      input logic [kmp_pkg::VOWEL_W-1:0] v,
      input logic [CW-1:0]               cnt
   );
      kmp_pkg::rsp_type r;
      logic [XW-1:0] cx;
      cx = XW'(cnt);
      r = '0;
      r.kind = kmp_pkg::KIND_MORA;
      r.consonant = c;
      r.vowel = v;
      r.mora_index = (cx > XW'(255)) ? 8'd255 : cx[7:0];
      return r;
   endfunction

   function automatic kmp_pkg::rsp_type phrase_rec(
      input logic [kmp_pkg::ACC_W-1:0]   acc,
      input logic [CW-1:0]               cnt,
      input logic [kmp_pkg::CODE_W-1:0]  delim,
      input logic [kmp_pkg::PAUSE_W-1:0] pz
   );
      kmp_pkg::rsp_type r;
      logic [XW-1:0] cx;
      cx = XW'(cnt);
      r = '0;
      r.kind = kmp_pkg::KIND_PHRASE;
      r.accent_pos = acc;
      r.mora_total = (cx > XW'(511)) ? 9'd511 : cx[8:0];
      r.delimiter = delim;
      r.pause_ms = pz;
      return r;
   endfunction

   function automatic kmp_pkg::rsp_load_type push(
      input kmp_pkg::rsp_load_type b,
      input kmp_pkg::rsp_type      r
   );
      kmp_pkg::rsp_load_type o;
      o = b;
      if (b.count == 2'd0) begin
         o.first = r;
      end else begin
         o.second = r;
      end
      o.count = b.count + 2'd1;
      return o;
   endfunction

   function automatic logic [CW-1:0] count_inc(input logic [CW-1:0] cnt);
      return (cnt < CW'(MAX_MORAS)) ? cnt + CW'(1) : cnt;
   endfunction

   assign fire       = in_valid_ff && load_ok;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_op;
         in_code_ff <= req_code;
      end
   end

   // decode of the registered character
   always_comb begin
      is_kana  = (in_code_ff >= kmp_pkg::CH_KANA_FIRST) && (in_code_ff <= kmp_pkg::CH_KANA_LAST);
      kana     = kmp_pkg::kana_lookup(7'(in_code_ff - kmp_pkg::CH_KANA_FIRST));
      is_delim = (in_code_ff == kmp_pkg::CH_SPACE)      || (in_code_ff == kmp_pkg::CH_IDEO_SPACE) ||
                 (in_code_ff == kmp_pkg::CH_IDEO_COMMA) || (in_code_ff == kmp_pkg::CH_IDEO_STOP)  ||
                 (in_code_ff == kmp_pkg::CH_COMMA)      || (in_code_ff == kmp_pkg::CH_PERIOD)     ||
                 (in_code_ff == kmp_pkg::CH_QUESTION)   || (in_code_ff == kmp_pkg::CH_FW_QUEST)   ||
                 (in_code_ff == kmp_pkg::CH_SLASH);
      priority if (in_code_ff == kmp_pkg::CH_SPACE || in_code_ff == kmp_pkg::CH_IDEO_SPACE) begin
         pause = kmp_pkg::PAUSE_SPACE;
      end else if (in_code_ff == kmp_pkg::CH_IDEO_COMMA || in_code_ff == kmp_pkg::CH_COMMA) begin
         pause = kmp_pkg::PAUSE_COMMA;
      end else if (in_code_ff == kmp_pkg::CH_IDEO_STOP || in_code_ff == kmp_pkg::CH_PERIOD ||
                   in_code_ff == kmp_pkg::CH_QUESTION || in_code_ff == kmp_pkg::CH_FW_QUEST) begin
         pause = kmp_pkg::PAUSE_STOP;
      end else begin
         pause = kmp_pkg::PAUSE_NONE;
      end
      merge_v = merge_vowel(pend_cons_ff, pend_vowel_ff, kana.vowel);
      merged  = (in_op_ff == kmp_pkg::OP_CHAR) && !(is_delim && word_open_ff) && is_kana &&
                (kana.cons == kmp_pkg::CN_L) && pend_valid_ff && (merge_v != pend_vowel_ff);
      kana_conv = kana;
      if (kana.cons == kmp_pkg::CN_L) begin
         unique case (kana.vowel)
            kmp_pkg::VW_JA: kana_conv = '{kmp_pkg::CN_J, kmp_pkg::VW_A};
            kmp_pkg::VW_JU: kana_conv = '{kmp_pkg::CN_J, kmp_pkg::VW_U};
            kmp_pkg::VW_JO: kana_conv = '{kmp_pkg::CN_J, kmp_pkg::VW_O};
            default:        kana_conv.cons = kmp_pkg::CN_NONE;
         endcase
      end
   end

   // next state and results, in the order the results leave
   always_comb begin
      bundle         = '0;
      pend_valid_in  = pend_valid_ff;
      pend_cons_in   = pend_cons_ff;
      pend_vowel_in  = pend_vowel_ff;
      prev_cons_in   = prev_cons_ff;
      prev_vowel_in  = prev_vowel_ff;
      mora_count_in  = mora_count_ff;
      accent_at_in   = accent_at_ff;
      word_open_in   = word_open_ff;
      cnt_x          = '0;

      if (merged) begin
         bundle        = push(bundle, mora_rec(pend_cons_ff, merge_v, mora_count_in));
         prev_cons_in  = pend_cons_ff;
         prev_vowel_in = merge_v;
         mora_count_in = count_inc(mora_count_in);
         pend_valid_in = 1'b0;
      end else if (pend_valid_ff) begin
         // held mora leaves ahead of anything else
         bundle        = push(bundle, mora_rec(pend_cons_ff, pend_vowel_ff, mora_count_in));
         prev_cons_in  = pend_cons_ff;
         prev_vowel_in = pend_vowel_ff;
         mora_count_in = count_inc(mora_count_in);
         pend_valid_in = 1'b0;
      end

      priority if (in_op_ff == kmp_pkg::OP_FLUSH) begin
         if (word_open_ff) begin
            bundle = push(bundle, phrase_rec(accent_at_in, mora_count_in, '0,
                                             kmp_pkg::PAUSE_NONE));
            mora_count_in = '0;
            accent_at_in  = kmp_pkg::ACC_NONE;
            word_open_in  = 1'b0;
         end
      end else if (is_delim && word_open_ff) begin
         bundle = push(bundle, phrase_rec(accent_at_in, mora_count_in, in_code_ff, pause));
         mora_count_in = '0;
         accent_at_in  = kmp_pkg::ACC_NONE;
         word_open_in  = 1'b0;
      end else begin
         word_open_in = 1'b1;
         priority if (is_kana) begin
            if (!merged) begin
               pend_valid_in = 1'b1;
               pend_cons_in  = kana_conv.cons;
               pend_vowel_in = kana_conv.vowel;
            end
         end else if (in_code_ff == kmp_pkg::CH_LONG_MARK) begin
            if (mora_count_in != '0) begin
               if (prev_cons_in == kmp_pkg::CN_NN) begin
                  bundle = push(bundle, mora_rec(kmp_pkg::CN_NN, kmp_pkg::VW_X, mora_count_in));
                  prev_vowel_in = kmp_pkg::VW_X;
               end else begin
                  bundle = push(bundle, mora_rec(kmp_pkg::CN_NONE, prev_vowel_in, mora_count_in));
                  prev_cons_in = kmp_pkg::CN_NONE;
               end
               mora_count_in = count_inc(mora_count_in);
            end
         end else if (in_code_ff == kmp_pkg::CH_ACCENT) begin
            if (mora_count_in != '0) begin
               cnt_x = XW'(mora_count_in) - XW'(1);
               accent_at_in = (cnt_x > XW'(255)) ? 9'd255 : {1'b0, cnt_x[7:0]};
            end
         end else begin
         end
      end

      if (bundle.count == 2'd1) begin
         bundle.first.last = 1'b1;
      end
      if (bundle.count == 2'd2) begin
         bundle.second.last = 1'b1;
      end
      bundle.load = fire;
   end

   assign rsp_load = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_cons_ff  <= '0;
         pend_vowel_ff <= '0;
         prev_cons_ff  <= '0;
         prev_vowel_ff <= '0;
         mora_count_ff <= '0;
         accent_at_ff  <= kmp_pkg::ACC_NONE;
         word_open_ff  <= 1'b0;
      end else if (fire) begin
         pend_valid_ff <= pend_valid_in;
         pend_cons_ff  <= pend_cons_in;
         pend_vowel_ff <= pend_vowel_in;
         prev_cons_ff  <= prev_cons_in;
         prev_vowel_ff <= prev_vowel_in;
         mora_count_ff <= mora_count_in;
         accent_at_ff  <= accent_at_in;
         word_open_ff  <= word_open_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      mora_count_ff <= CW'(MAX_MORAS))
      else $error("mora count beyond limit");

   a_accent_range: assert property (@(posedge clock) disable iff (reset)
      !accent_at_ff[kmp_pkg::ACC_W-1] || accent_at_ff == kmp_pkg::ACC_NONE)
      else $error("accent position out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      fire && in_op_ff == kmp_pkg::OP_FLUSH |=> !pend_valid_ff && !word_open_ff &&
      mora_count_ff == '0)
      else $error("end of text left phrase state behind");

endmodule

// ----- hdl/kmp_rsp_queue.sv -----
// Two-entry result register of the kana-to-mora parser; drives the rsp channel.
// Loaded by kmp_parse_stage only when it is empty or drains this cycle; depends on kmp_pkg.
module kmp_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  kmp_pkg::rsp_load_type rsp_load,
   output logic                  load_ok,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kmp_pkg::rsp_type      rsp_item
);

   logic [1:0]        count_ff;
   kmp_pkg::rsp_type  slot0_ff;
   kmp_pkg::rsp_type  slot1_ff;
   logic              pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = slot0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign load_ok   = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (rsp_load.load) begin
         count_ff <= rsp_load.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
      if (rsp_load.load) begin
         slot0_ff <= rsp_load.first;
         slot1_ff <= rsp_load.second;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue overfilled");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> load_ok)
      else $error("load into occupied result queue");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("last flag misplaced in result pair");

endmodule

// ----- hdl/kana_to_mora_phrase_parser_unit.sv -----
// Kana-to-mora phrase parser, top level: input register, parse logic, result register.
// Path: an accepted transaction is held in the input register, and its results in the result register.
// Throughput: one transaction per cycle while each yields at most one result and
// rsp_tready stays high; a transaction with two results holds the result register until both leave.
// Reset: synchronous, active high; clears the held mora, counts and accent mark.
// Depends on kmp_pkg, kmp_parse_stage and kmp_rsp_queue.
module kana_to_mora_phrase_parser_unit #(
   parameter int MAX_MORAS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [4:0] consonant, [8:5] vowel, [16:9] mora_index,
                                    // [25:17] accent_pos, [34:26] mora_total,
                                    // [50:35] delimiter, [60:51] pause_ms, [63:61] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);

   kmp_pkg::rsp_load_type rsp_load;
   kmp_pkg::rsp_type      rsp_item;
   logic                  load_ok;

   kmp_parse_stage #(
      .MAX_MORAS (MAX_MORAS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_code   (req_tdata),
      .load_ok    (load_ok),
      .rsp_load   (rsp_load)
   );

   kmp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_load  (rsp_load),
      .load_ok   (load_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.pause_ms, rsp_item.delimiter, rsp_item.mora_total,
                       rsp_item.accent_pos, rsp_item.mora_index, rsp_item.vowel,
                       rsp_item.consonant};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule
